// ===== sv/obb_pkg.sv =====
// Shared constants and codes for the 2D oriented box overlap test.
// Used by obb_sin, obb_overlap_test_2d and its testbench; depends on nothing else.
package obb_pkg;

  // Trig values are Q24 magnitudes up to 1.0, so 25 bits unsigned, 26 signed
  localparam int unsigned TRIG_FRAC    = 24;
  localparam int unsigned SIN_W        = 25;
  localparam int unsigned TRIG_W       = 26;
  localparam int unsigned HORNER_TERMS = 7;
  // obb_sin: phase product, square, three stages per Horner term, final product, rounding
  localparam int unsigned SIN_LAT      = 3 * HORNER_TERMS + 4;

  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

  typedef enum logic [2:0] {
    DEC_OVERLAP = 3'd0,
    DEC_CIRCLE  = 3'd1,
    DEC_AXIS_B1 = 3'd2,
    DEC_AXIS_B2 = 3'd3,
    DEC_AXIS_A1 = 3'd4,
    DEC_AXIS_A2 = 3'd5
  } dec_e;

endpackage

// ===== sv/obb_sin.sv =====
// Pipelined sine of a phase inside one quadrant, Q24 result, SIN_LAT stages.
// Taylor series by Horner in unsigned Q30; constant divides by reciprocal.
// Depends on obb_pkg.
module obb_sin #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ANGLE_BITS-2:0]         phase_i,
  output logic [obb_pkg::SIN_W-1:0]     sin_o
);
  import obb_pkg::*;

  localparam int unsigned PW = ANGLE_BITS - 1;
  localparam int unsigned XW = PW + 33;

  logic [XW-1:0] xprod;
  logic [30:0]   x_q;
  logic [61:0]   x2prod;
  logic [31:0]   x2_q;
  logic [30:0]   xa_q;

  logic [31:0] x2_c [HORNER_TERMS+1];
  logic [30:0] x_c  [HORNER_TERMS+1];
  logic [30:0] t_c  [HORNER_TERMS+1];

  logic [61:0]      vprod;
  logic [31:0]      v;
  logic [30:0]      v_q;
  logic [31:0]      rsum;
  logic [SIN_W-1:0] sin_q;

  // Scale the phase to radians in Q30
  assign xprod = XW'(phase_i) * XW'(TWO_PI_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= xprod[ANGLE_BITS +: 31];
    end
  end

  // Square of the angle
  assign x2prod = 62'(x_q) * 62'(x_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q <= x2prod[61:30];
      xa_q <= x_q;
    end
  end

  assign x2_c[0] = x2_q;
  assign x_c[0]  = xa_q;
  assign t_c[0]  = Q30_ONE;

  // One Horner term per three stages: product, reciprocal, correction
  for (genvar i = 0; i < HORNER_TERMS; i++) begin : g_term
    localparam int unsigned     K    = HORNER_TERMS - i;
    localparam int unsigned     DIV  = 2 * K * (2 * K + 1);
    localparam longint unsigned RECP = (64'd1 << 32) / DIV;

    logic [62:0] pa;
    logic [61:0] pb;
    logic [37:0] pc;
    logic [31:0] rem;
    logic [30:0] quo;
    logic [31:0] y_q, yb_q;
    logic [29:0] q0_q;
    logic [31:0] x2a_q, x2b_q, x2c_q;
    logic [30:0] xa_q2, xb_q, xc_q;
    logic [30:0] t_q;

    assign pa  = 63'(x2_c[i]) * 63'(t_c[i]);
    assign pb  = 62'(y_q) * 62'(RECP);
    assign pc  = 38'(q0_q) * 38'(DIV);
    assign rem = yb_q - pc[31:0];
    assign quo = {1'b0, q0_q} + 31'(rem >= 32'(DIV));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        y_q   <= pa[61:30];
        x2a_q <= x2_c[i];
        xa_q2 <= x_c[i];
        q0_q  <= pb[61:32];
        yb_q  <= y_q;
        x2b_q <= x2a_q;
        xb_q  <= xa_q2;
        t_q   <= Q30_ONE - quo;
        x2c_q <= x2b_q;
        xc_q  <= xb_q;
      end
    end

    assign x2_c[i+1] = x2c_q;
    assign x_c[i+1]  = xc_q;
    assign t_c[i+1]  = t_q;
  end

  // Final product, clamp to one, round to Q24
  assign vprod = 62'(x_c[HORNER_TERMS]) * 62'(t_c[HORNER_TERMS]);
  assign v     = vprod[61:30];
  assign rsum  = 32'(v_q) + 32'd32;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= (v > 32'(Q30_ONE)) ? Q30_ONE : v[30:0];
      sin_q <= rsum[30:6];
    end
  end

  assign sin_o = sin_q;

endmodule

// ===== sv/obb_overlap_test_2d.sv =====
// Overlap test for two rotated rectangles: bounding circles, then four separating axes.
// Top level; instantiates six obb_sin pipelines. Depends on obb_pkg and obb_sin.
//
// One box pair enters per clock while the output does not stall; the sine pipelines (seven
// Horner terms, three stages each) set the pipeline depth, and the ceil-sqrt of the circle
// test, two root bits per stage, runs alongside them.
// A stalled output freezes the whole pipeline; a one-word skid register keeps taking
// input meanwhile, and in_stall_o rises only once that word is full.
module obb_overlap_test_2d #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] a_center_x_i,
  input  logic signed [COORD_BITS-1:0] a_center_y_i,
  input  logic        [COORD_BITS-2:0] a_width_i,
  input  logic        [COORD_BITS-2:0] a_height_i,
  input  logic        [ANGLE_BITS-1:0] a_angle_i,
  input  logic signed [COORD_BITS-1:0] b_center_x_i,
  input  logic signed [COORD_BITS-1:0] b_center_y_i,
  input  logic        [COORD_BITS-2:0] b_width_i,
  input  logic        [COORD_BITS-2:0] b_height_i,
  input  logic        [ANGLE_BITS-1:0] b_angle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         overlap_o,
  output logic [2:0]                   decided_by_o
);
  import obb_pkg::*;

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned SW     = CB - 1;
  localparam int unsigned DW     = CB + 1;
  localparam int unsigned SQW    = 2 * SW + 1;
  localparam int unsigned TW     = 2 * CB + 1;
  localparam int unsigned SQ_STG = (CB + 1) / 2;
  localparam int unsigned LIMW   = CB + 2;
  localparam int unsigned DSW    = 2 * CB + 3;
  localparam int unsigned CMPW   = 2 * CB + 5;
  localparam int unsigned PDW    = DW + TRIG_W;
  localparam int unsigned PSW    = SW + SIN_W;
  localparam int unsigned LW     = CB + 28;
  localparam int unsigned PW     = ANGLE_BITS - 1;
  localparam int unsigned T      = SIN_LAT;
  localparam int unsigned LAST   = T + 4;
  localparam int unsigned N_REJ  = T - 2 - SQ_STG;
  localparam int unsigned N_DIST = SQ_STG + 1;

  typedef struct packed {
    logic signed [CB-1:0]     ax;
    logic signed [CB-1:0]     ay;
    logic [SW-1:0]            aw;
    logic [SW-1:0]            ah;
    logic [ANGLE_BITS-1:0]    aang;
    logic signed [CB-1:0]     bx;
    logic signed [CB-1:0]     by;
    logic [SW-1:0]            bw;
    logic [SW-1:0]            bh;
    logic [ANGLE_BITS-1:0]    bang;
  } in_t;

  typedef struct packed {
    logic [SQW-1:0] rem;
    logic [CB-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  // One bit of the restoring square root
  function automatic sq_t sq_step(sq_t st, int unsigned j);
    logic [TW-1:0] test;
    sq_t           res;
    test = (TW'(st.root) << (j + 1)) + (TW'(1) << (2 * j));
    res  = st;
    if (TW'(st.rem) >= test) begin
      res.rem  = st.rem - test[SQW-1:0];
      res.root = st.root | (CB'(1) << j);
    end
    return res;
  endfunction

  // Quadrant symmetry from the two phase sines
  function automatic trig_t quad_map(logic [1:0] q, logic [SIN_W-1:0] s0,
                                     logic [SIN_W-1:0] s1);
    trig_t r;
    logic signed [TRIG_W-1:0] p0, p1;
    p0 = $signed({1'b0, s0});
    p1 = $signed({1'b0, s1});
    case (q)
      2'd0:    begin r.s = p0;  r.c = p1;  end
      2'd1:    begin r.s = p1;  r.c = -p0; end
      2'd2:    begin r.s = -p0; r.c = -p1; end
      default: begin r.s = -p1; r.c = p0;  end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- flow control
  logic            en;
  logic [LAST:0]   vld_q;
  logic            skid_vld_q;
  in_t             skid_q;
  in_t             in_word;
  in_t             p0_q;
  logic            in_acc;

  assign in_word = '{ax: a_center_x_i, ay: a_center_y_i, aw: a_width_i, ah: a_height_i,
                     aang: a_angle_i, bx: b_center_x_i, by: b_center_y_i, bw: b_width_i,
                     bh: b_height_i, bang: b_angle_i};

  assign en         = !(vld_q[LAST] && out_stall_i);
  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;

  // Advance valid bits; park one word while frozen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      skid_vld_q <= 1'b0;
    end else if (en) begin
      vld_q      <= {vld_q[LAST-1:0], skid_vld_q || in_acc};
      skid_vld_q <= 1'b0;
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q <= skid_vld_q ? skid_q : in_word;
    end else if (in_acc) begin
      skid_q <= in_word;
    end
  end

  // ---------------------------------------------------------------- sines
  logic [ANGLE_BITS-1:0] dang;
  logic [ANGLE_BITS-1:0] ang [3];
  logic [PW-1:0]         ph  [6];
  logic [SIN_W-1:0]      sn  [6];

  assign dang   = p0_q.aang - p0_q.bang;
  assign ang[0] = p0_q.aang;
  assign ang[1] = p0_q.bang;
  assign ang[2] = dang;

  for (genvar g = 0; g < 3; g++) begin : g_ang
    assign ph[2*g]   = {1'b0, ang[g][ANGLE_BITS-3:0]};
    assign ph[2*g+1] = (PW'(1) << (ANGLE_BITS - 2)) - {1'b0, ang[g][ANGLE_BITS-3:0]};
  end

  for (genvar g = 0; g < 6; g++) begin : g_sin
    obb_sin #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
      .clk_i  (clk_i),
      .en_i   (en),
      .phase_i(ph[g]),
      .sin_o  (sn[g])
    );
  end

  // ---------------------------------------------------------------- circle test
  logic [2*SW-1:0]        wa2_q, ha2_q, wb2_q, hb2_q;
  logic signed [DW-1:0]   dx_q, dy_q;
  logic [DW-1:0]          mdx, mdy;
  logic [SQW-1:0]         va_q, vb_q;
  logic [2*DW-1:0]        dx2_q, dy2_q;
  logic [DSW-1:0]         dist_q;
  sq_t                    sqa_q [SQ_STG];
  sq_t                    sqb_q [SQ_STG];
  logic [LIMW-1:0]        lim_q;
  logic [2*LIMW-1:0]      lim2_q;
  logic                   rej_q;
  logic [DSW-1:0]         dist_dq [N_DIST];
  logic                   rej_dq  [N_REJ];
  sq_t                    sqa_f, sqb_f;

  assign mdx = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign mdy = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);

  // Square sizes, take centre differences, then sum
  always_ff @(posedge clk_i) begin
    if (en) begin
      wa2_q  <= (2*SW)'(p0_q.aw) * (2*SW)'(p0_q.aw);
      ha2_q  <= (2*SW)'(p0_q.ah) * (2*SW)'(p0_q.ah);
      wb2_q  <= (2*SW)'(p0_q.bw) * (2*SW)'(p0_q.bw);
      hb2_q  <= (2*SW)'(p0_q.bh) * (2*SW)'(p0_q.bh);
      dx_q   <= $signed({p0_q.ax[CB-1], p0_q.ax}) - $signed({p0_q.bx[CB-1], p0_q.bx});
      dy_q   <= $signed({p0_q.ay[CB-1], p0_q.ay}) - $signed({p0_q.by[CB-1], p0_q.by});
      va_q   <= SQW'(wa2_q) + SQW'(ha2_q);
      vb_q   <= SQW'(wb2_q) + SQW'(hb2_q);
      dx2_q  <= (2*DW)'(mdx) * (2*DW)'(mdx);
      dy2_q  <= (2*DW)'(mdy) * (2*DW)'(mdy);
      dist_q <= DSW'(dx2_q) + DSW'(dy2_q);
    end
  end

  // Square roots, two bits per stage
  for (genvar s = 0; s < SQ_STG; s++) begin : g_sqrt
    localparam int J0 = int'(CB) - 1 - 2 * s;
    sq_t ina, inb, oa, ob, ma, mb;

    if (s == 0) begin : g_first
      assign ina = '{rem: va_q, root: '0};
      assign inb = '{rem: vb_q, root: '0};
    end else begin : g_next
      assign ina = sqa_q[s-1];
      assign inb = sqb_q[s-1];
    end

    assign ma = sq_step(ina, J0);
    assign mb = sq_step(inb, J0);

    if (J0 >= 1) begin : g_two
      assign oa = sq_step(ma, J0 - 1);
      assign ob = sq_step(mb, J0 - 1);
    end else begin : g_one
      assign oa = ma;
      assign ob = mb;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sqa_q[s] <= oa;
        sqb_q[s] <= ob;
      end
    end
  end

  assign sqa_f = sqa_q[SQ_STG-1];
  assign sqb_f = sqb_q[SQ_STG-1];

  // Round roots up, square the radius sum, compare
  always_ff @(posedge clk_i) begin
    if (en) begin
      lim_q  <= LIMW'(sqa_f.root) + LIMW'(sqa_f.rem != '0) + LIMW'(sqb_f.root)
                + LIMW'(sqb_f.rem != '0) + LIMW'(1);
      lim2_q <= (2*LIMW)'(lim_q) * (2*LIMW)'(lim_q);
      rej_q  <= (CMPW'(dist_dq[N_DIST-1]) << 2) >= CMPW'(lim2_q);
    end
  end

  // ---------------------------------------------------------------- delay lines
  logic [5:0]      quad_src;
  logic [5:0]      quad_dq [T];
  logic [4*SW-1:0] size_dq [T+1];
  logic [2*DW-1:0] dd_dq   [T];

  assign quad_src = {ang[0][ANGLE_BITS-1 -: 2], ang[1][ANGLE_BITS-1 -: 2],
                     ang[2][ANGLE_BITS-1 -: 2]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      quad_dq[0] <= quad_src;
      for (int k = 1; k < T; k++) quad_dq[k] <= quad_dq[k-1];
      size_dq[0] <= {p0_q.aw, p0_q.ah, p0_q.bw, p0_q.bh};
      for (int k = 1; k < T + 1; k++) size_dq[k] <= size_dq[k-1];
      dd_dq[0] <= {dx_q, dy_q};
      for (int k = 1; k < T; k++) dd_dq[k] <= dd_dq[k-1];
      dist_dq[0] <= dist_q;
      for (int k = 1; k < N_DIST; k++) dist_dq[k] <= dist_dq[k-1];
      rej_dq[0] <= rej_q;
      for (int k = 1; k < N_REJ; k++) rej_dq[k] <= rej_dq[k-1];
    end
  end

  // ---------------------------------------------------------------- axis tests
  trig_t                    ta, tb;
  logic signed [TRIG_W-1:0] sa_q, ca_q, sb_q, cb_q;
  logic [SIN_W-1:0]         kc_q, ks_q;
  logic [1:0]               qa, qb, qd;

  assign {qa, qb, qd} = quad_dq[T-1];
  assign ta = quad_map(qa, sn[0], sn[1]);
  assign tb = quad_map(qb, sn[2], sn[3]);

  // Resolve quadrants
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q <= ta.s;
      ca_q <= ta.c;
      sb_q <= tb.s;
      cb_q <= tb.c;
      kc_q <= qd[0] ? sn[4] : sn[5];
      ks_q <= qd[0] ? sn[5] : sn[4];
    end
  end

  logic [SW-1:0]            aw_d, ah_d, bw_d, bh_d;
  logic signed [DW-1:0]     dx_d, dy_d;
  logic signed [TRIG_W-1:0] ux [4];
  logic signed [TRIG_W-1:0] uy [4];
  logic [SW-1:0]            own [4];
  logic [SW-1:0]            ow  [4];
  logic [SW-1:0]            oh  [4];
  logic [SIN_W-1:0]         k1  [4];
  logic [SIN_W-1:0]         k2  [4];
  logic signed [PDW-1:0]    pdx_q [4];
  logic signed [PDW-1:0]    pdy_q [4];
  logic [PSW-1:0]           pw_q  [4];
  logic [PSW-1:0]           ph_q  [4];
  logic [SW-1:0]            own_q [4];
  logic [3:0]               sep_q;
  logic                     rej_f;

  assign {aw_d, ah_d, bw_d, bh_d} = size_dq[T];
  assign {dx_d, dy_d}             = dd_dq[T-1];

  // Axis order: B width edge, B height edge, A width edge, A height edge
  assign ux[0] = cb_q;  assign uy[0] = sb_q;  assign own[0] = bw_d;
  assign ux[1] = -sb_q; assign uy[1] = cb_q;  assign own[1] = bh_d;
  assign ux[2] = ca_q;  assign uy[2] = sa_q;  assign own[2] = aw_d;
  assign ux[3] = -sa_q; assign uy[3] = ca_q;  assign own[3] = ah_d;
  assign ow[0] = aw_d;  assign oh[0] = ah_d;  assign k1[0] = kc_q; assign k2[0] = ks_q;
  assign ow[1] = aw_d;  assign oh[1] = ah_d;  assign k1[1] = ks_q; assign k2[1] = kc_q;
  assign ow[2] = bw_d;  assign oh[2] = bh_d;  assign k1[2] = kc_q; assign k2[2] = ks_q;
  assign ow[3] = bw_d;  assign oh[3] = bh_d;  assign k1[3] = ks_q; assign k2[3] = kc_q;

  for (genvar a = 0; a < 4; a++) begin : g_axis
    logic signed [LW-1:0] dot;
    logic [LW-1:0]        lhs, rhs;

    assign dot = LW'(pdx_q[a]) + LW'(pdy_q[a]);
    assign lhs = (dot[LW-1] ? LW'(-dot) : LW'(dot)) << 1;
    assign rhs = (LW'(own_q[a]) << TRIG_FRAC) + LW'(pw_q[a]) + LW'(ph_q[a]);

    // Project, then compare gap against the half extents
    always_ff @(posedge clk_i) begin
      if (en) begin
        pdx_q[a] <= dx_d * ux[a];
        pdy_q[a] <= dy_d * uy[a];
        pw_q[a]  <= PSW'(ow[a]) * PSW'(k1[a]);
        ph_q[a]  <= PSW'(oh[a]) * PSW'(k2[a]);
        own_q[a] <= own[a];
        sep_q[a] <= (own_q[a] == '0) || (lhs >= rhs);
      end
    end
  end

  // ---------------------------------------------------------------- result
  dec_e dec_q;

  assign rej_f = rej_dq[N_REJ-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rej_f)         dec_q <= DEC_CIRCLE;
      else if (sep_q[0]) dec_q <= DEC_AXIS_B1;
      else if (sep_q[1]) dec_q <= DEC_AXIS_B2;
      else if (sep_q[2]) dec_q <= DEC_AXIS_A1;
      else if (sep_q[3]) dec_q <= DEC_AXIS_A2;
      else               dec_q <= DEC_OVERLAP;
    end
  end

  assign out_valid_o  = vld_q[LAST];
  assign overlap_o    = (dec_q == DEC_OVERLAP);
  assign decided_by_o = dec_q;

  // ---------------------------------------------------------------- checks
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(!en))
    else $error("skid word filled while the pipeline advanced");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (vld_q == $past(vld_q)))
    else $error("valid bits moved during a stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && en) |=> vld_q[0])
    else $error("accepted word did not enter the first stage");

endmodule

// ===== verif/obb_overlap_test_2d_tb.sv =====
// Self-checking testbench for obb_overlap_test_2d: directed and random box pairs,
// predicted in-bench with integer trig, circle and axis tests. Depends on obb_pkg.
module obb_overlap_test_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import obb_pkg::*;

  localparam int CW = 24;
  localparam int AW = 16;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned QTR = 64'd1 << (AW - 2);

  typedef struct packed {
    logic signed [CW-1:0] ax, ay;
    logic [CW-2:0] aw, ah;
    logic [AW-1:0] aa;
    logic signed [CW-1:0] bx, by;
    logic [CW-2:0] bw, bh;
    logic [AW-1:0] ba;
  } pair_t;

  typedef struct packed {
    logic ovl;
    logic [2:0] dec;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pair_t cur = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic overlap_o;
  logic [2:0] decided_by_o;
  logic in_taken = 1'b0;

  pair_t pending_q[$];
  verdict_t verdict_q[$];
  int errors = 0;
  int sent = 0;
  int results = 0;
  int hold_left = 0;
  bit hold_done = 0;
  bit stim_done = 0;

  always #6 clk_i = ~clk_i;

  obb_overlap_test_2d dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .a_center_x_i(cur.ax), .a_center_y_i(cur.ay), .a_width_i(cur.aw),
    .a_height_i(cur.ah), .a_angle_i(cur.aa),
    .b_center_x_i(cur.bx), .b_center_y_i(cur.by), .b_width_i(cur.bw),
    .b_height_i(cur.bh), .b_angle_i(cur.ba),
    .out_valid_o, .out_stall_i, .overlap_o, .decided_by_o
  );

  // sine of a phase inside one quadrant, Q24
  function automatic longint quad_sin(longint unsigned r);
    longint unsigned x, x2, t, v, d;
    x = (r * (2 * PI_Q30)) >> AW;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int k = 7; k >= 1; k--) begin
      d = longint'(2 * k) * longint'(2 * k + 1);
      t = ONE_Q30 - ((x2 * t) >> 30) / d;
    end
    v = (x * t) >> 30;
    if (v > ONE_Q30) v = ONE_Q30;
    return longint'((v + 32) >> 6);
  endfunction

  function automatic void rot_sincos(input logic [AW-1:0] a, output longint s,
                                     output longint c);
    longint s0, s1;
    s0 = quad_sin(a[AW-3:0]);
    s1 = quad_sin(QTR - a[AW-3:0]);
    case (a[AW-1:AW-2])
      2'd0: begin s = s0; c = s1; end
      2'd1: begin s = s1; c = -s0; end
      2'd2: begin s = -s0; c = -s1; end
      default: begin s = -s1; c = s0; end
    endcase
  endfunction

  function automatic longint unsigned root_up(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (v != 0) res++;
    return res;
  endfunction

  function automatic longint unsigned absv(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic bit axis_splits(longint ux, longint uy, longint dx, longint dy,
                                     longint unsigned own, longint unsigned ow,
                                     longint unsigned oh, longint unsigned kw,
                                     longint unsigned kh);
    if (own == 0) return 1'b1;
    return 2 * absv(dx * ux + dy * uy) >= (own << TRIG_FRAC) + ow * kw + oh * kh;
  endfunction

  function automatic verdict_t classify_pair(pair_t p);
    longint dx, dy, sa, ca, sb, cb, sd, cd;
    longint unsigned lim, dist2, kc, ks;
    logic [AW-1:0] rel;
    dec_e code;
    verdict_t r;
    dx = longint'(p.ax) - longint'(p.bx);
    dy = longint'(p.ay) - longint'(p.by);
    lim = root_up(longint'(p.aw) * p.aw + longint'(p.ah) * p.ah)
        + root_up(longint'(p.bw) * p.bw + longint'(p.bh) * p.bh) + 1;
    dist2 = 4 * absv(dx) * absv(dx) + 4 * absv(dy) * absv(dy);
    code = DEC_OVERLAP;
    if (dist2 >= lim * lim) begin
      code = DEC_CIRCLE;
    end else begin
      rot_sincos(p.aa, sa, ca);
      rot_sincos(p.ba, sb, cb);
      rel = p.aa - p.ba;
      rot_sincos(rel, sd, cd);
      kc = absv(cd);
      ks = absv(sd);
      if (axis_splits(cb, sb, dx, dy, p.bw, p.aw, p.ah, kc, ks)) code = DEC_AXIS_B1;
      else if (axis_splits(-sb, cb, dx, dy, p.bh, p.aw, p.ah, ks, kc)) code = DEC_AXIS_B2;
      else if (axis_splits(ca, sa, dx, dy, p.aw, p.bw, p.bh, kc, ks)) code = DEC_AXIS_A1;
      else if (axis_splits(-sa, ca, dx, dy, p.ah, p.bw, p.bh, ks, kc)) code = DEC_AXIS_A2;
    end
    r.ovl = (code == DEC_OVERLAP);
    r.dec = code;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // append one word to the stimulus queue
  task automatic queue_pair(pair_t p);
    pending_q = {pending_q, p};
  endtask

  function automatic pair_t rand_pair();
    logic [223:0] raw;
    pair_t p;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p = raw[$bits(pair_t)-1:0];
    return p;
  endfunction

  // boxes of moderate size placed near each other, so the axis tests get exercised
  function automatic pair_t near_pair();
    pair_t p;
    int span;
    span = ($urandom_range(0, 9) == 0) ? 2000000 : 3000;
    p = rand_pair();
    p.aw = 23'($urandom_range(0, span));
    p.ah = 23'($urandom_range(0, span));
    p.bw = 23'($urandom_range(0, span));
    p.bh = 23'($urandom_range(0, span));
    p.bx = p.ax + $signed(24'($urandom_range(0, 2 * span))) - 24'(span);
    p.by = p.ay + $signed(24'($urandom_range(0, 2 * span))) - 24'(span);
    return p;
  endfunction

  // Directed words: extremes, every rotation quadrant, zero-length edges
  task automatic load_directed();
    pair_t p;
    queue_pair('0);
    p = '1;
    queue_pair(p);
    p = '0;
    p.ax = 24'sh7fffff; p.ay = 24'sh7fffff; p.bx = 24'sh800000; p.by = 24'sh800000;
    p.aw = '1; p.ah = '1; p.bw = '1; p.bh = '1;
    queue_pair(p);
    p.ax = 24'sh7fffff; p.bx = 24'sh800000; p.ay = '0; p.by = '0;
    p.aw = '0; p.ah = '0; p.bw = '0; p.bh = '0;
    queue_pair(p);
    for (int q = 0; q < 5; q++) begin
      p = '0;
      p.aw = 23'd1000; p.ah = 23'd300; p.bw = 23'd800; p.bh = 23'd200;
      p.ax = 24'sd500; p.ay = 24'sd200;
      p.aa = (q == 4) ? 16'hffff : 16'(q * 16384);
      p.ba = 16'(q * 8192 + 100);
      queue_pair(p);
    end
    // each word gives one edge of one box zero length
    for (int z = 0; z < 4; z++) begin
      p = '0;
      p.aw = (z == 0) ? 23'd0 : 23'd600; p.ah = (z == 1) ? 23'd0 : 23'd600;
      p.bw = (z == 2) ? 23'd0 : 23'd600; p.bh = (z == 3) ? 23'd0 : 23'd600;
      p.bx = 24'sd100;
      queue_pair(p);
    end
    // touching along an axis, and circles just touching
    p = '0; p.aw = 23'd1000; p.ah = 23'd1000; p.bw = 23'd1000; p.bh = 23'd1000;
    p.bx = 24'sd1000;
    queue_pair(p);
    p.bx = 24'sd999;
    queue_pair(p);
    p = '0; p.aw = 23'd300; p.ah = 23'd400; p.bw = 23'd300; p.bh = 23'd400;
    p.bx = 24'sd500; p.by = '0;
    queue_pair(p);
    p.bx = 24'sd501;
    queue_pair(p);
    p = '0; p.aw = 23'd1000; p.ah = 23'd100; p.bw = 23'd1000; p.bh = 23'd100;
    p.by = 24'sd300;
    p.aa = 16'd16384; p.ba = 16'd16384;
    queue_pair(p);
    p.aa = 16'd8192; p.ba = 16'd57344; p.bx = 24'sh800000;
    queue_pair(p);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    load_directed();
    for (int i = 0; i < 1600; i++)
      queue_pair(($urandom_range(0, 3) == 0) ? rand_pair() : near_pair());
    stim_done = 1;
  end

  // Driver: present the next word once the current one is taken
  always @(negedge clk_i) begin
    int idle_pct;
    idle_pct = (sent < 540) ? 31 : (sent < 1080) ? 46 : 0;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        cur <= pending_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall, plus one long hold so the pipeline backs up
  always @(negedge clk_i) begin
    int stall_pct;
    stall_pct = (sent < 540) ? 46 : (sent < 1080) ? 31 : 0;
    if (!hold_done && results >= 700) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: predict on accepted input words, check accepted output words
  always @(posedge clk_i) begin
    verdict_t want;
    in_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      verdict_q = {verdict_q, classify_pair(cur)};
      sent++;
    end
    if (out_valid_o && !out_stall_i) begin
      results++;
      if (verdict_q.size() == 0) begin
        report_mismatch("result word with no expectation pending");
      end else begin
        want = verdict_q.pop_front();
        if (overlap_o !== want.ovl)
          report_mismatch($sformatf("overlap got %b want %b", overlap_o, want.ovl));
        if (decided_by_o !== want.dec)
          report_mismatch($sformatf("decided_by got %0d want %0d", decided_by_o, want.dec));
      end
    end
  end

  // Drain, then give the pipeline time to show any stray word
  initial begin
    wait (stim_done && rst_ni);
    @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("timeout waiting for results");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
